// ----- design/ini_line_tokenizer_core_assert.svh -----
// ----------------------------------------------------------------------------
// ini line tokenizer assertion macros
// concurrent assertion helpers, compiled out when ASSERT_OFF is set
// ----------------------------------------------------------------------------
`ifndef INI_LINE_TOKENIZER_CORE_ASSERT_SVH
`define INI_LINE_TOKENIZER_CORE_ASSERT_SVH
`ifndef ASSERT_OFF
`define ILTK_ASSERT(label, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("iltk assertion failed");
`define ILTK_ASSERT_RST(label, prop) \
	label: assert property (@(posedge clk) prop) \
		else $error("iltk reset assertion failed");
`else
`define ILTK_ASSERT(label, prop)
`define ILTK_ASSERT_RST(label, prop)
`endif
`endif

// ----- design/iltk_pkg.sv -----
// ----------------------------------------------------------------------------
// iltk_pkg
// shared constants, codes and control structs of the ini line tokenizer
// ----------------------------------------------------------------------------
package iltk_pkg;

	localparam int TOKEN_MAX_DEF = 63;

	localparam logic [7:0] CH_EOT   = 8'h00;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_SEMI  = 8'h3B;
	localparam logic [7:0] CH_EQ    = 8'h3D;
	localparam logic [7:0] CH_LBR   = 8'h5B;
	localparam logic [7:0] CH_RBR   = 8'h5D;
	localparam logic [7:0] CH_DROP  = 8'h7F;

	localparam logic [1:0] KIND_SECTION = 2'd0;
	localparam logic [1:0] KIND_KEY     = 2'd1;
	localparam logic [1:0] KIND_VALUE   = 2'd2;

	typedef struct packed {
		logic       store;
		logic       clear;
		logic       emit_begin;
		logic       rd_en;
		logic       load;
		logic [1:0] kind;
	} ctrl_cmd_t;

	typedef struct packed {
		logic out_free;
		logic tok_empty;
		logic rd_last;
	} dp_stat_t;

endpackage

// ----- design/iltk_datapath.sv -----
// ----------------------------------------------------------------------------
// iltk_datapath
// token store, length and overflow tracking, replay pointer, output register
// ----------------------------------------------------------------------------
module iltk_datapath #(
	parameter int TOKEN_MAX = iltk_pkg::TOKEN_MAX_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  iltk_pkg::ctrl_cmd_t  cmd,
	input  logic [7:0]           in_byte,
	output iltk_pkg::dp_stat_t   stat,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [7:0]           m_tdata,
	output logic [3:0]           m_tuser,
	output logic                 m_tlast
);

	localparam int ADDR_W = $clog2(TOKEN_MAX);
	localparam int LEN_W  = $clog2(TOKEN_MAX + 1);

	logic [7:0]        mem [TOKEN_MAX];
	logic [LEN_W-1:0]  len_q;
	logic              ovf_q;
	logic [ADDR_W-1:0] rd_ptr_q;
	logic [7:0]        rdata_q;
	logic              has_room;

	logic              out_valid_q;
	logic [7:0]        out_byte_q;
	logic [1:0]        out_kind_q;
	logic              out_empty_q;
	logic              out_trunc_q;
	logic              out_last_q;

	assign has_room       = len_q < LEN_W'(TOKEN_MAX);
	assign stat.out_free  = !out_valid_q || m_tready;
	assign stat.tok_empty = len_q == '0;
	assign stat.rd_last   = (LEN_W'(rd_ptr_q) + LEN_W'(1)) == len_q;

	always_ff @(posedge clk) begin
		if (cmd.store && has_room) begin
			mem[len_q[ADDR_W-1:0]] <= in_byte;
		end
		if (cmd.rd_en) begin
			rdata_q <= mem[rd_ptr_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q    <= '0;
			ovf_q    <= 1'b0;
			rd_ptr_q <= '0;
		end else begin
			if (cmd.clear) begin
				len_q <= '0;
				ovf_q <= 1'b0;
			end else if (cmd.store) begin
				if (has_room) begin
					len_q <= len_q + LEN_W'(1);
				end else begin
					ovf_q <= 1'b1;
				end
			end
			if (cmd.emit_begin) begin
				rd_ptr_q <= '0;
			end else if (cmd.load && !stat.rd_last && !stat.tok_empty) begin
				rd_ptr_q <= rd_ptr_q + ADDR_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			out_byte_q  <= stat.tok_empty ? 8'h00 : rdata_q;
			out_kind_q  <= cmd.kind;
			out_empty_q <= stat.tok_empty;
			out_trunc_q <= ovf_q;
			out_last_q  <= stat.tok_empty || stat.rd_last;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_byte_q;
	assign m_tuser  = {out_trunc_q, out_empty_q, out_kind_q};
	assign m_tlast  = out_last_q;

`include "ini_line_tokenizer_core_assert.svh"

	`ILTK_ASSERT(a_len_bound, len_q <= LEN_W'(TOKEN_MAX))
	`ILTK_ASSERT(a_ovf_full, ovf_q |-> (len_q == LEN_W'(TOKEN_MAX)))
	`ILTK_ASSERT(a_load_free, cmd.load |-> stat.out_free)
	`ILTK_ASSERT(a_rd_in_range, (cmd.rd_en && !stat.tok_empty) |-> (LEN_W'(rd_ptr_q) < len_q))
	`ILTK_ASSERT_RST(a_reset_len, !arst_n |=> (len_q == '0))

endmodule

// ----- design/iltk_ctrl.sv -----
// ----------------------------------------------------------------------------
// iltk_ctrl
// parse state machine and token replay sequencer
// ----------------------------------------------------------------------------
module iltk_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [7:0]           s_tdata,
	input  iltk_pkg::dp_stat_t   stat,
	output iltk_pkg::ctrl_cmd_t  cmd
);

	typedef enum logic [1:0] {
		MODE_IDLE,
		MODE_SECTION,
		MODE_KEY,
		MODE_VALUE
	} mode_t;

	typedef enum logic [1:0] {
		ST_IN,
		ST_RD,
		ST_LD
	} state_t;

	state_t     state_q, state_d;
	mode_t      mode_q, mode_d;
	logic       comment_q, comment_d;
	logic [7:0] prev_q, prev_d;
	logic [1:0] kind_q, kind_d;
	logic       accept;
	logic       emit;

	assign s_tready = state_q == ST_IN;
	assign accept   = s_tvalid && s_tready;

	always_comb begin
		state_d        = state_q;
		mode_d         = mode_q;
		comment_d      = comment_q;
		prev_d         = prev_q;
		kind_d         = kind_q;
		emit           = 1'b0;
		cmd            = '0;
		cmd.kind       = kind_q;
		case (state_q)
			ST_IN: begin
				if (accept) begin
					if (s_tdata == iltk_pkg::CH_EOT) begin
						if (mode_q == MODE_VALUE) begin
							emit   = 1'b1;
							kind_d = iltk_pkg::KIND_VALUE;
						end else begin
							cmd.clear = 1'b1;
						end
						mode_d    = MODE_IDLE;
						comment_d = 1'b0;
						prev_d    = '0;
					end else if (comment_q && s_tdata != iltk_pkg::CH_LF) begin
						prev_d = iltk_pkg::CH_DROP;
					end else if (s_tdata == iltk_pkg::CH_SEMI) begin
						comment_d = 1'b1;
						prev_d    = iltk_pkg::CH_DROP;
					end else if (s_tdata == iltk_pkg::CH_TAB || s_tdata == iltk_pkg::CH_DROP) begin
						comment_d = 1'b0;
						prev_d    = iltk_pkg::CH_DROP;
					end else begin
						comment_d = 1'b0;
						prev_d    = s_tdata;
						case (mode_q)
							MODE_IDLE: begin
								if (s_tdata == iltk_pkg::CH_LBR) begin
									mode_d    = MODE_SECTION;
									cmd.store = 1'b1;
								end else if (s_tdata != iltk_pkg::CH_SPACE &&
									s_tdata != iltk_pkg::CH_LF) begin
									mode_d    = MODE_KEY;
									cmd.store = 1'b1;
								end
							end
							MODE_SECTION: begin
								if (s_tdata == iltk_pkg::CH_LF) begin
									mode_d    = MODE_IDLE;
									cmd.clear = 1'b1;
								end else if (s_tdata == iltk_pkg::CH_RBR) begin
									cmd.store = 1'b1;
									emit      = 1'b1;
									kind_d    = iltk_pkg::KIND_SECTION;
									mode_d    = MODE_IDLE;
								end else begin
									cmd.store = 1'b1;
								end
							end
							MODE_KEY: begin
								if (s_tdata == iltk_pkg::CH_LF) begin
									mode_d    = MODE_IDLE;
									cmd.clear = 1'b1;
								end else if (s_tdata == iltk_pkg::CH_EQ) begin
									emit   = 1'b1;
									kind_d = iltk_pkg::KIND_KEY;
									mode_d = MODE_VALUE;
								end else begin
									cmd.store = 1'b1;
								end
							end
							default: begin
								if (s_tdata == iltk_pkg::CH_SPACE && prev_q == iltk_pkg::CH_EQ) begin
									// single space after the equals sign is skipped
								end else if (s_tdata == iltk_pkg::CH_LF) begin
									emit   = 1'b1;
									kind_d = iltk_pkg::KIND_VALUE;
									mode_d = MODE_IDLE;
								end else begin
									cmd.store = 1'b1;
								end
							end
						endcase
					end
					if (emit) begin
						cmd.emit_begin = 1'b1;
						state_d        = ST_RD;
					end
				end
			end
			ST_RD: begin
				cmd.rd_en = 1'b1;
				state_d   = ST_LD;
			end
			ST_LD: begin
				if (stat.out_free) begin
					cmd.load = 1'b1;
					if (stat.tok_empty || stat.rd_last) begin
						cmd.clear = 1'b1;
						state_d   = ST_IN;
					end else begin
						state_d = ST_RD;
					end
				end
			end
			default: begin
				state_d = ST_IN;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IN;
			mode_q    <= MODE_IDLE;
			comment_q <= 1'b0;
			prev_q    <= '0;
			kind_q    <= iltk_pkg::KIND_SECTION;
		end else begin
			state_q   <= state_d;
			mode_q    <= mode_d;
			comment_q <= comment_d;
			prev_q    <= prev_d;
			kind_q    <= kind_d;
		end
	end

endmodule

// ----- design/ini_line_tokenizer_core.sv -----
// ----------------------------------------------------------------------------
// ini_line_tokenizer_core
// byte-serial ini tokenizer that replays sections, keys and values
// ----------------------------------------------------------------------------
// input stream s_*: one text byte per transaction in s_tdata, zero ends the
// text and returns the parser to its reset state (a pending value is sent).
// output stream m_*: one transaction per token byte; m_tlast marks the final
// byte of a token, m_tuser carries kind, empty flag and truncation flag.
// a byte that completes no token leaves the input ready for the next one.
// each byte of a completed token is read from the store and then loaded
// into the output register (an empty token gives one zero byte); no input
// is taken during replay. bytes beyond TOKEN_MAX are dropped and flagged.
// a single output register holds the last result, so input resumes while
// it waits; a stall on m_tready holds replay of the next byte.
// reset clears the parse state, length and overflow; the token store itself
// needs no clearing, only written entries are replayed.
// ----------------------------------------------------------------------------
module ini_line_tokenizer_core #(
	parameter int TOKEN_MAX = iltk_pkg::TOKEN_MAX_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // text_byte
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,   // token_byte
	output logic [3:0] m_tuser,   // token_kind[1:0], empty_token, truncated
	output logic       m_tlast
);

	iltk_pkg::ctrl_cmd_t cmd;
	iltk_pkg::dp_stat_t  stat;

	iltk_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.stat     (stat),
		.cmd      (cmd)
	);

	iltk_datapath #(
		.TOKEN_MAX (TOKEN_MAX)
	) u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.in_byte  (s_tdata),
		.stat     (stat),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

endmodule

// ----- tb/sv/tb_ini_line_tokenizer_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ini_line_tokenizer_core
// drives ini text bytes into the tokenizer, a directed table first and then
// randomly built lines, with random gaps on the input and stalls on the
// output. a parser model or the table rows predict every token transaction and
// each output transaction is compared in order against those predictions.
// ----------------------------------------------------------------------------
module tb_ini_line_tokenizer_core;

	localparam int TOKEN_MAX   = iltk_pkg::TOKEN_MAX_DEF;
	localparam int CYCLE_LIMIT = 400000;
	localparam int RAND_ITEMS  = 385;

	typedef enum logic [1:0] {PM_IDLE, PM_SECTION, PM_KEY, PM_VALUE} scan_mode_t;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] data;
		logic       empty;
		logic       last;
		logic       cut;
	} token_beat_t;

	typedef struct {
		logic [7:0]  text;
		int          typed_n;
		token_beat_t beat;
	} directed_row_t;

	localparam token_beat_t NO_BEAT = '0;

	logic       clk = 1'b0;
	logic       arst_n;
	logic       s_tvalid;
	logic       s_tready;
	logic [7:0] s_tdata;
	logic       m_tvalid;
	logic       m_tready;
	logic [7:0] m_tdata;
	logic [3:0] m_tuser;
	logic       m_tlast;

	token_beat_t beats_due[$];
	token_beat_t fresh_beats[$];
	logic [7:0]  text_q[$];
	int          errors = 0;
	int          cycles = 0;
	bit          calm = 1'b0;

	scan_mode_t  scan_mode;
	logic        in_remark;
	logic [7:0]  prior_byte;
	logic [7:0]  tok_buf [TOKEN_MAX];
	int          tok_len;
	logic        tok_cut;

	// typed rows: typed_n 0 or 1 gives the results directly, -1 uses the model
	directed_row_t directed_rows [25] = '{
		'{"a",                0, NO_BEAT},
		'{iltk_pkg::CH_EQ,    1, '{iltk_pkg::KIND_KEY, "a", 1'b0, 1'b1, 1'b0}},
		'{iltk_pkg::CH_LF,    1, '{iltk_pkg::KIND_VALUE, 8'h00, 1'b1, 1'b1, 1'b0}},
		'{iltk_pkg::CH_LBR,   0, NO_BEAT},
		'{8'hFF,              0, NO_BEAT},
		'{iltk_pkg::CH_RBR,  -1, NO_BEAT},
		'{"k",                0, NO_BEAT},
		'{iltk_pkg::CH_TAB,   0, NO_BEAT},
		'{iltk_pkg::CH_EQ,    1, '{iltk_pkg::KIND_KEY, "k", 1'b0, 1'b1, 1'b0}},
		'{iltk_pkg::CH_SPACE, 0, NO_BEAT},
		'{"v",                0, NO_BEAT},
		'{iltk_pkg::CH_SEMI,  0, NO_BEAT},
		'{"x",                0, NO_BEAT},
		'{iltk_pkg::CH_LF,    1, '{iltk_pkg::KIND_VALUE, "v", 1'b0, 1'b1, 1'b0}},
		'{iltk_pkg::CH_EQ,    0, NO_BEAT},
		'{iltk_pkg::CH_LF,    0, NO_BEAT},
		'{iltk_pkg::CH_LBR,   0, NO_BEAT},
		'{"s",                0, NO_BEAT},
		'{iltk_pkg::CH_LF,    0, NO_BEAT},
		'{"q",                0, NO_BEAT},
		'{iltk_pkg::CH_EQ,    1, '{iltk_pkg::KIND_KEY, "q", 1'b0, 1'b1, 1'b0}},
		'{iltk_pkg::CH_DROP,  0, NO_BEAT},
		'{iltk_pkg::CH_SPACE, 0, NO_BEAT},
		'{8'h01,              0, NO_BEAT},
		'{iltk_pkg::CH_EOT,  -1, NO_BEAT}
	};

	ini_line_tokenizer_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic void parser_reset();
		scan_mode  = PM_IDLE;
		in_remark  = 1'b0;
		prior_byte = 8'h00;
		tok_len    = 0;
		tok_cut    = 1'b0;
	endfunction

	function automatic void stash_byte(logic [7:0] b);
		if (tok_len < TOKEN_MAX) begin
			tok_buf[tok_len] = b;
			tok_len++;
		end else begin
			tok_cut = 1'b1;
		end
	endfunction

	function automatic void replay_token(logic [1:0] kind);
		token_beat_t beat;
		if (tok_len == 0) begin
			beat = '{kind, 8'h00, 1'b1, 1'b1, tok_cut};
			fresh_beats.push_back(beat);
		end else begin
			for (int i = 0; i < tok_len; i++) begin
				beat = '{kind, tok_buf[i], 1'b0, (i == tok_len - 1), tok_cut};
				fresh_beats.push_back(beat);
			end
		end
		tok_len = 0;
		tok_cut = 1'b0;
	endfunction

	function automatic void tokenize_byte(logic [7:0] b);
		logic [7:0] prev;
		prev = prior_byte;
		fresh_beats.delete();
		if (b == iltk_pkg::CH_EOT) begin
			if (scan_mode == PM_VALUE)
				replay_token(iltk_pkg::KIND_VALUE);
			parser_reset();
			return;
		end
		if (in_remark && b != iltk_pkg::CH_LF) begin
			prior_byte = iltk_pkg::CH_DROP;
			return;
		end
		in_remark = 1'b0;
		if (b == iltk_pkg::CH_SEMI) begin
			in_remark  = 1'b1;
			prior_byte = iltk_pkg::CH_DROP;
			return;
		end
		if (b == iltk_pkg::CH_TAB || b == iltk_pkg::CH_DROP) begin
			prior_byte = iltk_pkg::CH_DROP;
			return;
		end
		prior_byte = b;
		case (scan_mode)
			PM_IDLE: begin
				if (b == iltk_pkg::CH_LBR) begin
					scan_mode = PM_SECTION;
					stash_byte(b);
				end else if (b != iltk_pkg::CH_SPACE && b != iltk_pkg::CH_LF) begin
					scan_mode = PM_KEY;
					stash_byte(b);
				end
			end
			PM_SECTION: begin
				if (b == iltk_pkg::CH_LF) begin
					scan_mode = PM_IDLE;
					tok_len   = 0;
					tok_cut   = 1'b0;
				end else if (b == iltk_pkg::CH_RBR) begin
					stash_byte(b);
					replay_token(iltk_pkg::KIND_SECTION);
					scan_mode = PM_IDLE;
				end else begin
					stash_byte(b);
				end
			end
			PM_KEY: begin
				if (b == iltk_pkg::CH_LF) begin
					scan_mode = PM_IDLE;
					tok_len   = 0;
					tok_cut   = 1'b0;
				end else if (b == iltk_pkg::CH_EQ) begin
					replay_token(iltk_pkg::KIND_KEY);
					scan_mode = PM_VALUE;
				end else begin
					stash_byte(b);
				end
			end
			default: begin
				if (b == iltk_pkg::CH_SPACE && prev == iltk_pkg::CH_EQ) begin
					// single space after the equals sign is skipped
				end else if (b == iltk_pkg::CH_LF) begin
					replay_token(iltk_pkg::KIND_VALUE);
					scan_mode = PM_IDLE;
				end else begin
					stash_byte(b);
				end
			end
		endcase
	endfunction

	function automatic logic [7:0] word_char();
		int r;
		r = $urandom_range(0, 99);
		if (r < 80)
			return 8'($urandom_range(97, 122));
		if (r < 86)
			return iltk_pkg::CH_SPACE;
		if (r < 90)
			return iltk_pkg::CH_TAB;
		if (r < 93)
			return iltk_pkg::CH_DROP;
		return 8'($urandom_range(1, 255));
	endfunction

	function automatic void add_line();
		int pick;
		int n;
		pick = $urandom_range(0, 99);
		if (pick < 12) begin
			text_q.push_back(iltk_pkg::CH_LBR);
			repeat ($urandom_range(0, 8)) text_q.push_back(word_char());
			text_q.push_back(iltk_pkg::CH_RBR);
			text_q.push_back(iltk_pkg::CH_LF);
		end else if (pick < 55) begin
			if ($urandom_range(0, 3) == 0)
				text_q.push_back(iltk_pkg::CH_SPACE);
			repeat ($urandom_range(1, 8)) text_q.push_back(word_char());
			text_q.push_back(iltk_pkg::CH_EQ);
			if ($urandom_range(0, 1) == 1)
				text_q.push_back(iltk_pkg::CH_SPACE);
			repeat ($urandom_range(0, 10)) text_q.push_back(word_char());
			if ($urandom_range(0, 4) == 0) begin
				text_q.push_back(iltk_pkg::CH_SEMI);
				repeat ($urandom_range(0, 5)) text_q.push_back(word_char());
			end
			text_q.push_back(($urandom_range(0, 9) == 0) ? iltk_pkg::CH_EOT : iltk_pkg::CH_LF);
		end else if (pick < 62) begin
			text_q.push_back(iltk_pkg::CH_SEMI);
			repeat ($urandom_range(0, 8)) text_q.push_back(word_char());
			text_q.push_back(iltk_pkg::CH_LF);
		end else if (pick < 70) begin
			if ($urandom_range(0, 1) == 1)
				text_q.push_back(iltk_pkg::CH_LBR);
			repeat ($urandom_range(0, 8)) text_q.push_back(word_char());
			text_q.push_back(iltk_pkg::CH_LF);
		end else if (pick < 74) begin
			// long token that can exceed TOKEN_MAX: either the key, the value or a section
			n = $urandom_range(0, 2);
			if (n == 2)
				text_q.push_back(iltk_pkg::CH_LBR);
			repeat ((n != 1) ? $urandom_range(60, 90) : $urandom_range(1, 4))
				text_q.push_back(8'($urandom_range(97, 122)));
			text_q.push_back((n == 2) ? iltk_pkg::CH_RBR : iltk_pkg::CH_EQ);
			repeat ((n == 1) ? $urandom_range(60, 90) : $urandom_range(0, 4))
				text_q.push_back(8'($urandom_range(97, 122)));
			text_q.push_back(iltk_pkg::CH_LF);
		end else if (pick < 80) begin
			if ($urandom_range(0, 2) == 0)
				text_q.push_back(iltk_pkg::CH_SEMI);
			repeat ($urandom_range(0, 4)) text_q.push_back(word_char());
			text_q.push_back(iltk_pkg::CH_EOT);
		end else if (pick < 88) begin
			repeat ($urandom_range(0, 3)) text_q.push_back(iltk_pkg::CH_SPACE);
			text_q.push_back(iltk_pkg::CH_LF);
		end else begin
			repeat ($urandom_range(1, 6)) text_q.push_back(8'($urandom_range(0, 255)));
		end
	endfunction

	task automatic feed_byte(input logic [7:0] b, input bit predicted);
		if (!calm && $urandom_range(0, 99) < 10) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		tokenize_byte(b);
		if (predicted)
			foreach (fresh_beats[i]) beats_due.push_back(fresh_beats[i]);
		@(negedge clk);
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (beats_due.size() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	always @(negedge clk) begin
		m_tready <= calm ? 1'b1 : ($urandom_range(0, 99) >= 10);
	end

	always @(posedge clk) begin : out_check
		token_beat_t got;
		token_beat_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got = '{m_tuser[1:0], m_tdata, m_tuser[2], m_tlast, m_tuser[3]};
			if (beats_due.size() == 0) begin
				$display("%0t: unexpected transaction, got kind %0d byte %h empty %b last %b cut %b",
					$time, got.kind, got.data, got.empty, got.last, got.cut);
				errors++;
			end else begin
				want = beats_due.pop_front();
				if (got.kind !== want.kind || got.data !== want.data ||
						got.empty !== want.empty || got.last !== want.last ||
						got.cut !== want.cut) begin
					$display("%0t: token mismatch, expected kind %0d byte %h empty %b last %b cut %b",
						$time, want.kind, want.data, want.empty, want.last, want.cut,
						", got kind %0d byte %h empty %b last %b cut %b",
						got.kind, got.data, got.empty, got.last, got.cut);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("%0t: timeout with %0d transactions outstanding", $time, beats_due.size());
			$display("== FAIL ==");
			$finish;
		end
	end

	initial begin : stimulus
		int sent;
		logic [7:0] b;
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = 8'h00;
		m_tready = 1'b0;
		parser_reset();
		repeat (5) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (directed_rows[i]) begin
			feed_byte(directed_rows[i].text, directed_rows[i].typed_n < 0);
			if (directed_rows[i].typed_n == 1)
				beats_due.push_back(directed_rows[i].beat);
		end
		wait_drained();

		sent = 0;
		while (sent < RAND_ITEMS) begin
			if (text_q.size() == 0)
				add_line();
			if (sent == 150 && !calm)
				wait_drained();
			calm = (sent >= 150 && sent < 230);
			b = text_q.pop_front();
			feed_byte(b, 1'b1);
			sent++;
		end

		calm = 1'b0;
		wait_drained();
		repeat (2 * TOKEN_MAX + 20) @(negedge clk);
		if (errors == 0 && beats_due.size() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
